### rtl/csoq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csoq_pkg: shared types and codes for the circular sector order queue
// Request and response transfer formats, operation and status codes.
// ----------------------------------------------------------------------------
package csoq_pkg;

   localparam int DefQueueDepth = 64;
   localparam int DefSectorBits = 48;
   localparam int DefTagBits    = 8;

   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_DISPATCH = 2'd1;
   localparam logic [1:0] OP_REMOVE   = 2'd2;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [47:0] sector;
      logic        is_write;
      logic [7:0]  tag;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] out_sector;
      logic        out_write;
      logic [7:0]  out_tag;
      logic [6:0]  occupancy;
   } rsp_type_type;

endpackage

### rtl/circular_sector_order_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_sector_order_queue_core: C-LOOK ordered disk request queue
// Requests sit on a circular linked list in ascending sector order held in
// one synchronous entry memory (sector, direction, tag, link).
//
// Usage: req_valid/req_ready carries one operation (add, dispatch head,
// remove by tag); rsp_valid/rsp_ready returns exactly one response per
// request. One operation is in work at a time.
// Each operation that finds entries to search walks the list entry by
// entry, with a read, a wait and a compare step per entry, so the time to
// rsp_valid grows with count (occupancy). After each response transfer
// the core returns to idle, where the next request is accepted.
// The walk is set by the single read port of the entry memory.
// Reset: queue empties, all slots free, head at slot 0; no clearing pass.
// A stalled response is held in the output register; the next request is
// accepted once the response transfer completes.
// ----------------------------------------------------------------------------
module circular_sector_order_queue_core #(
   parameter int QUEUE_DEPTH = csoq_pkg::DefQueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  csoq_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output csoq_pkg::rsp_type_type rsp_data
);
   import csoq_pkg::*;

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [47:0]   sector;
      logic          wr;
      logic [7:0]    tag;
      logic [IW-1:0] link;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_A, S_WAIT_A, S_RD_B, S_WAIT_B, S_LINK_RD, S_LINK_WAIT,
      S_FIN, S_RESP
   } state_type;

   entry_type     mem [QUEUE_DEPTH];
   entry_type     rdata_ff;
   logic [IW-1:0] raddr;
   logic          we;
   logic [IW-1:0] waddr;
   entry_type     wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   state_type     state_ff;
   req_type_type  req_ff;
   rsp_type_type  rsp_ff;
   logic [QUEUE_DEPTH-1:0] free_ff;
   logic [IW-1:0] head_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] n_ff;
   logic [IW-1:0] cur_ff;
   logic [IW-1:0] prev_ff;
   logic [IW-1:0] slot_ff;
   logic [IW-1:0] after_ff;
   logic [IW-1:0] tail_ff;
   logic [IW-1:0] vlink_ff;
   entry_type     a_ff;
   logic          found_ff;
   logic [IW-1:0] rd_addr_ff;

   logic [IW-1:0] free_slot;
   always_comb begin
      free_slot = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (free_ff[i]) free_slot = IW'(i);
      end
   end

   logic [1:0] start_status;
   logic [7:0] start_tag;
   state_type  start_state;
   always_comb begin
      start_status = ST_DONE;
      start_tag    = req_data.tag;
      start_state  = S_RD_A;
      case (req_data.req_type)
         OP_ADD: begin
            if (count_ff == CW'(QUEUE_DEPTH)) begin
               start_status = ST_FULL;
               start_state  = S_RESP;
            end else if (count_ff == '0) begin
               start_state = S_FIN;
            end
         end
         OP_DISPATCH: begin
            start_tag = '0;
            if (count_ff == '0) begin
               start_status = ST_EMPTY;
               start_state  = S_RESP;
            end
         end
         OP_REMOVE: begin
            if (count_ff == '0) begin
               start_status = ST_EMPTY;
               start_state  = S_RESP;
            end
         end
         default: begin
            start_tag   = '0;
            start_state = S_RESP;
         end
      endcase
   end

   logic [IW-1:0] pred_idx;
   assign pred_idx  = (after_ff == head_ff) ? tail_ff : prev_ff;

   assign raddr     = rd_addr_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   logic [47:0] sec_n;
   logic        between;
   assign sec_n   = req_ff.sector;
   assign between = (sec_n > a_ff.sector && sec_n < rdata_ff.sector) ||
                    (rdata_ff.sector < a_ff.sector &&
                     (sec_n > a_ff.sector || sec_n < rdata_ff.sector));

   always_comb begin
      we    = 1'b0;
      waddr = slot_ff;
      wdata = '{sector: req_ff.sector, wr: req_ff.is_write, tag: req_ff.tag,
                link: slot_ff};
      if (state_ff == S_FIN && req_ff.req_type == OP_ADD) begin
         we = 1'b1;
         if (count_ff != '0) wdata.link = rdata_ff.link;
      end else if (state_ff == S_RESP && req_ff.req_type == OP_ADD &&
                   rsp_ff.status == ST_DONE && count_ff != CW'(1)) begin
         we         = 1'b1;
         waddr      = after_ff;
         wdata      = a_ff;
         wdata.link = slot_ff;
      end else if (state_ff == S_LINK_WAIT && req_ff.req_type != OP_ADD) begin
         we         = 1'b1;
         waddr      = prev_ff;
         wdata      = rdata_ff;
         wdata.link = vlink_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff  <= '1;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff     <= req_data;
                  rsp_ff     <= '{status: start_status, out_sector: '0,
                                  out_write: 1'b0, out_tag: start_tag,
                                  occupancy: 7'(count_ff)};
                  n_ff       <= '0;
                  cur_ff     <= head_ff;
                  tail_ff    <= head_ff;
                  rd_addr_ff <= head_ff;
                  found_ff   <= 1'b0;
                  slot_ff    <= free_slot;
                  state_ff   <= start_state;
               end
            end
            S_RD_A: state_ff <= S_WAIT_A;
            S_WAIT_A: begin
               a_ff       <= rdata_ff;
               rd_addr_ff <= rdata_ff.link;
               if (n_ff == '0 && req_ff.req_type == OP_DISPATCH) begin
                  rsp_ff <= '{status: rsp_ff.status, out_sector: rdata_ff.sector,
                              out_write: rdata_ff.wr, out_tag: rdata_ff.tag,
                              occupancy: rsp_ff.occupancy};
               end
               if (!found_ff &&
                   ((req_ff.req_type == OP_DISPATCH && n_ff == '0) ||
                    (req_ff.req_type == OP_REMOVE && rdata_ff.tag == req_ff.tag))) begin
                  found_ff <= 1'b1;
                  after_ff <= cur_ff;
                  prev_ff  <= tail_ff;
                  vlink_ff <= rdata_ff.link;
               end
               tail_ff  <= cur_ff;
               state_ff <= S_RD_B;
            end
            S_RD_B: state_ff <= S_WAIT_B;
            S_WAIT_B: begin
               if (req_ff.req_type == OP_ADD && between) begin
                  found_ff   <= 1'b1;
                  after_ff   <= cur_ff;
                  rd_addr_ff <= cur_ff;
                  state_ff   <= S_LINK_RD;
               end else if (n_ff + CW'(1) >= count_ff) begin
                  if (req_ff.req_type == OP_ADD) begin
                     after_ff   <= cur_ff;
                     rd_addr_ff <= cur_ff;
                     state_ff   <= S_LINK_RD;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end else begin
                  n_ff     <= n_ff + CW'(1);
                  cur_ff   <= a_ff.link;
                  state_ff <= S_WAIT_A;
               end
            end
            S_LINK_RD: state_ff <= S_LINK_WAIT;
            S_LINK_WAIT: begin
               if (req_ff.req_type == OP_ADD) begin
                  rd_addr_ff <= after_ff;
                  state_ff   <= S_FIN;
               end else begin
                  state_ff <= S_RESP;
               end
            end
            S_FIN: begin
               case (req_ff.req_type)
                  OP_ADD: begin
                     free_ff[slot_ff] <= 1'b0;
                     count_ff <= count_ff + CW'(1);
                     rsp_ff.occupancy <= 7'(count_ff + CW'(1));
                     if (count_ff == '0) head_ff <= slot_ff;
                     a_ff     <= rdata_ff;
                     found_ff <= 1'b0;
                     state_ff <= S_RESP;
                  end
                  default: begin
                     if (found_ff) begin
                        free_ff[after_ff] <= 1'b1;
                        count_ff <= count_ff - CW'(1);
                        rsp_ff.occupancy <= 7'(count_ff - CW'(1));
                        if (count_ff == CW'(1)) begin
                           head_ff  <= '0;
                           state_ff <= S_RESP;
                        end else begin
                           if (after_ff == head_ff) head_ff <= vlink_ff;
                           prev_ff    <= pred_idx;
                           rd_addr_ff <= pred_idx;
                           state_ff   <= S_LINK_RD;
                        end
                     end else begin
                        rsp_ff.status <= ST_NOTFOUND;
                        state_ff      <= S_RESP;
                     end
                  end
               endcase
            end
            S_RESP: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data));

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid));

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH));

   a_free_count: assert property (@(posedge clock) disable iff (reset)
      CW'($countones(~free_ff)) == count_ff);

endmodule
